>>> sv/mcrp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, opcodes, command and status types and speed helpers
// for the motor channel ramp profiler. Depends on nothing else.
package mcrp_pkg;

	localparam int TIME_W      = 32;
	localparam int SPD_W       = 8;
	localparam int MAG_W       = 7;
	localparam int STEP_W      = 7;
	localparam int PERIOD_W    = 16;
	localparam int SWCNT_W     = 8;
	localparam int OP_W        = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int BUDGET_W    = TIME_W + STEP_W;
	localparam int ADJ_MAG_W   = SPD_W + 1;
	localparam int ADJ_MS_W    = 17;
	localparam int MS_PER_S    = 1000;
	localparam int SPEED_LIMIT = 100;
	localparam int STEP_RESET   = 10;
	localparam int PERIOD_RESET = 100;

	localparam logic [OP_W-1:0] OP_BEGIN      = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK       = 3'd1;
	localparam logic [OP_W-1:0] OP_ADJ_DUR    = 3'd2;
	localparam logic [OP_W-1:0] OP_ADJ_SPEED  = 3'd3;
	localparam logic [OP_W-1:0] OP_END        = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLIDE_MODE    = 2'd2;

	typedef struct packed {
		logic begin_init;
		logic tgt_zero;
		logic tgt_load;
		logic end_clear;
		logic adj_mul;
		logic adj_apply;
		logic div_start;
		logic budget_mul;
		logic upd_apply;
		logic done_eval;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            busy;
		logic            tick_due;
		logic            spd_zero;
		logic            spd_change;
		logic            div_done;
		logic            out_free;
	} stat_t;

	function automatic logic signed [SPD_W-1:0] clamp_speed(input logic signed [SPD_W:0] v);
		logic signed [SPD_W:0] lim;
		logic signed [SPD_W:0] res;
		lim = (SPD_W + 1)'(SPEED_LIMIT);
		if (v > lim) begin
			res = lim;
		end else if (v < -lim) begin
			res = -lim;
		end else begin
			res = v;
		end
		return res[SPD_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] speed_mag(input logic signed [SPD_W-1:0] v);
		logic signed [SPD_W-1:0] a;
		a = v[SPD_W-1] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

endpackage

>>> sv/mcrp_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, for the remaining
// update periods. Depends on mcrp_pkg for its widths.
module mcrp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mcrp_pkg::TIME_W-1:0]   dividend,
	input  logic [mcrp_pkg::PERIOD_W-1:0] divisor,
	output logic [mcrp_pkg::TIME_W-1:0]   quotient,
	output logic                          done
);

	localparam int CNT_BITS = $clog2(mcrp_pkg::TIME_W + 1);

	logic [mcrp_pkg::TIME_W-1:0]   quo_q;
	logic [mcrp_pkg::PERIOD_W-1:0] rem_q;
	logic [mcrp_pkg::PERIOD_W-1:0] dvs_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          done_q;
	logic [mcrp_pkg::PERIOD_W:0]   rem_sh;
	logic [mcrp_pkg::PERIOD_W:0]   rem_sub;
	logic                          ge;
	logic [mcrp_pkg::PERIOD_W-1:0] rem_nx;

	assign rem_sh  = {rem_q, quo_q[mcrp_pkg::TIME_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_nx  = ge ? rem_sub[mcrp_pkg::PERIOD_W-1:0] : rem_sh[mcrp_pkg::PERIOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(mcrp_pkg::TIME_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[mcrp_pkg::TIME_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> sv/mcrp_dp.sv
`timescale 1ns / 1ps
// Datapath of the ramp profiler: item and configuration registers, channel
// state, period divider, brake budget, ramp logic and the result register.
// Depends on mcrp_pkg and mcrp_div; driven by mcrp_ctrl through cmd_t.
module mcrp_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic [mcrp_pkg::OP_W-1:0]              op_in,
	input  logic [mcrp_pkg::TIME_W-1:0]            now_in,
	input  logic signed [mcrp_pkg::SPD_W-1:0]      cmd_speed_in,
	input  logic [mcrp_pkg::TIME_W-1:0]            dur_in,
	input  logic signed [mcrp_pkg::SPD_W-1:0]      adj_s_in,
	input  logic signed [mcrp_pkg::SPD_W-1:0]      adj_v_in,
	input  logic [mcrp_pkg::SWCNT_W-1:0]           count_in,
	input  logic                                   cfg_we,
	input  logic [mcrp_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [mcrp_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  mcrp_pkg::cmd_t                         cmd,
	output mcrp_pkg::stat_t                        stat,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic                                   out_forward,
	output logic [mcrp_pkg::MAG_W-1:0]             out_mag,
	output logic                                   out_stop,
	output logic                                   out_done,
	output logic                                   out_busy
);

	localparam int TW = mcrp_pkg::TIME_W;
	localparam int SW = mcrp_pkg::SPD_W;

	logic [mcrp_pkg::OP_W-1:0]          op_q;
	logic [TW-1:0]                      now_q;
	logic signed [SW-1:0]               cmd_speed_q;
	logic [TW-1:0]                      dur_q;
	logic signed [SW-1:0]               adj_s_q;
	logic signed [SW-1:0]               adj_v_q;
	logic [mcrp_pkg::SWCNT_W-1:0]       count_q;

	logic [mcrp_pkg::STEP_W-1:0]        step_q;
	logic [mcrp_pkg::PERIOD_W-1:0]      period_q;
	logic                               slide_q;

	logic [TW-1:0]                      deadline_q;
	logic [TW-1:0]                      next_upd_q;
	logic signed [SW-1:0]               target_q;
	logic signed [SW-1:0]               present_q;
	logic [mcrp_pkg::SWCNT_W-1:0]       seen_q;
	logic                               done_q;
	logic                               out_valid_q;

	logic [mcrp_pkg::BUDGET_W-1:0]      budget_q;
	logic [mcrp_pkg::ADJ_MS_W-1:0]      adj_ms_q;
	logic                               fwd_q;
	logic [mcrp_pkg::MAG_W-1:0]         mag_q;
	logic                               stop_q;
	logic                               rdone_q;
	logic                               rbusy_q;

	logic                               busy;
	logic                               switch_hit;
	logic                               out_free;
	logic                               do_emit;
	logic signed [SW:0]                 spd_sum;
	logic signed [SW-1:0]               ns;
	logic [mcrp_pkg::PERIOD_W-1:0]      period_eff;
	logic [TW-1:0]                      rem_time;
	logic [TW-1:0]                      quo;
	logic                               div_done;
	logic signed [mcrp_pkg::ADJ_MAG_W-1:0] adj_ext;
	logic [mcrp_pkg::ADJ_MAG_W-1:0]     adj_mag;
	logic                               adj_pos;
	logic [TW-1:0]                      dl_grow;
	logic [TW-1:0]                      dl_cand;
	logic [TW-1:0]                      dl_adj;

	logic [SW-1:0]                      cur;
	logic [SW-1:0]                      tgt;
	logic [SW-1:0]                      stp;
	logic [SW-1:0]                      down_t;
	logic [SW-1:0]                      down_0;
	logic [SW-1:0]                      up_v;
	logic                               brake;
	logic [SW-1:0]                      new_mag;
	logic signed [SW-1:0]               new_tgt;
	logic                               write_p;
	logic                               neg;
	logic signed [SW-1:0]               nm_s;
	logic signed [SW-1:0]               new_present;

	assign busy       = deadline_q != '0;
	assign switch_hit = busy && slide_q && (count_q != seen_q);
	assign out_free   = !out_valid_q || out_ready;
	assign do_emit    = cmd.emit && out_free;

	assign spd_sum = {target_q[SW-1], target_q} + {adj_v_q[SW-1], adj_v_q};
	assign ns      = mcrp_pkg::clamp_speed(spd_sum);

	assign period_eff = (period_q == '0) ? mcrp_pkg::PERIOD_W'(1) : period_q;
	assign rem_time   = deadline_q - now_q;

	mcrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rem_time),
		.divisor  (period_eff),
		.quotient (quo),
		.done     (div_done)
	);

	assign adj_ext = {adj_s_q[SW-1], adj_s_q};
	assign adj_mag = adj_ext[mcrp_pkg::ADJ_MAG_W-1] ? mcrp_pkg::ADJ_MAG_W'(-adj_ext)
		: mcrp_pkg::ADJ_MAG_W'(adj_ext);
	assign adj_pos = !adj_s_q[SW-1] && (adj_s_q != '0);
	assign dl_grow = deadline_q + TW'(adj_ms_q);
	assign dl_cand = deadline_q - TW'(adj_ms_q);
	assign dl_adj  = adj_pos ? dl_grow : ((now_q >= dl_cand) ? now_q : dl_cand);

	assign cur    = {1'b0, mcrp_pkg::speed_mag(present_q)};
	assign tgt    = {1'b0, mcrp_pkg::speed_mag(target_q)};
	assign stp    = {1'b0, step_q};
	assign down_t = (cur > stp + tgt) ? cur - stp : tgt;
	assign down_0 = (cur > stp) ? cur - stp : '0;
	assign up_v   = (cur + stp < tgt) ? cur + stp : tgt;
	assign brake  = mcrp_pkg::BUDGET_W'(cur) >= budget_q;

	always_comb begin
		new_mag = cur;
		new_tgt = target_q;
		write_p = 1'b1;
		if (tgt < cur) begin
			new_mag = down_t;
		end else if (brake) begin
			new_tgt = '0;
			new_mag = down_0;
		end else if (tgt == cur) begin
			write_p = 1'b0;
		end else begin
			new_mag = up_v;
		end
		neg         = (present_q != '0) ? present_q[SW-1] : new_tgt[SW-1];
		nm_s        = new_mag;
		new_present = neg ? -nm_s : nm_s;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q        <= op_in;
			now_q       <= now_in;
			cmd_speed_q <= cmd_speed_in;
			dur_q       <= dur_in;
			adj_s_q     <= adj_s_in;
			adj_v_q     <= adj_v_in;
			count_q     <= count_in;
		end
		if (cmd.adj_mul) begin
			adj_ms_q <= mcrp_pkg::ADJ_MS_W'(adj_mag) * mcrp_pkg::ADJ_MS_W'(mcrp_pkg::MS_PER_S);
		end
		if (cmd.budget_mul) begin
			budget_q <= mcrp_pkg::BUDGET_W'(step_q) * mcrp_pkg::BUDGET_W'(quo);
		end
		if (do_emit) begin
			fwd_q   <= !present_q[SW-1];
			mag_q   <= mcrp_pkg::speed_mag(present_q);
			stop_q  <= present_q == '0;
			rdone_q <= done_q;
			rbusy_q <= busy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= mcrp_pkg::STEP_W'(mcrp_pkg::STEP_RESET);
			period_q    <= mcrp_pkg::PERIOD_W'(mcrp_pkg::PERIOD_RESET);
			slide_q     <= 1'b0;
			deadline_q  <= '0;
			next_upd_q  <= '0;
			target_q    <= '0;
			present_q   <= '0;
			seen_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					mcrp_pkg::REG_SPEED_STEP:    step_q   <= cfg_wdata[mcrp_pkg::STEP_W-1:0];
					mcrp_pkg::REG_UPDATE_PERIOD: period_q <= cfg_wdata[mcrp_pkg::PERIOD_W-1:0];
					mcrp_pkg::REG_SLIDE_MODE:    slide_q  <= cfg_wdata[0];
					default: ;
				endcase
			end

			if (cmd.begin_init) begin
				deadline_q <= now_q + dur_q;
				seen_q     <= count_q;
				target_q   <= mcrp_pkg::clamp_speed({cmd_speed_q[SW-1], cmd_speed_q});
				present_q  <= '0;
			end else if (cmd.end_clear) begin
				deadline_q <= '0;
				next_upd_q <= '0;
				target_q   <= '0;
				present_q  <= '0;
			end else if (cmd.tgt_zero) begin
				target_q <= '0;
			end else if (cmd.tgt_load) begin
				target_q <= ns;
			end else if (cmd.adj_apply) begin
				deadline_q <= dl_adj;
			end else if (cmd.upd_apply) begin
				next_upd_q <= now_q + TW'(period_q);
				target_q   <= new_tgt;
				if (write_p) begin
					present_q <= new_present;
				end
			end else if (cmd.done_eval) begin
				if (switch_hit) begin
					seen_q     <= count_q;
					deadline_q <= now_q;
					done_q     <= 1'b1;
				end else begin
					done_q <= busy && (now_q >= deadline_q);
				end
			end

			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.busy       = busy;
		stat.tick_due   = busy && (next_upd_q != '0) && (now_q >= next_upd_q);
		stat.spd_zero   = ns == '0;
		stat.spd_change = (ns != target_q) && (now_q < deadline_q);
		stat.div_done   = div_done;
		stat.out_free   = out_free;
	end

	assign out_valid   = out_valid_q;
	assign out_forward = fwd_q;
	assign out_mag     = mag_q;
	assign out_stop    = stop_q;
	assign out_done    = rdone_q;
	assign out_busy    = rbusy_q;

endmodule

>>> sv/mcrp_ctrl.sv
`timescale 1ns / 1ps
// Controller of the ramp profiler: decodes the opcode and sequences the
// datapath steps. Depends on mcrp_pkg; talks to mcrp_dp through cmd_t/stat_t.
module mcrp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  mcrp_pkg::stat_t stat,
	output mcrp_pkg::cmd_t  cmd,
	output logic            in_ready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_UPD_START,
		S_UPD_WAIT,
		S_UPD_MUL,
		S_UPD_APPLY,
		S_ADJ_MUL,
		S_ADJ_APPLY,
		S_DONE_CHK,
		S_EMIT
	} state_t;

	state_t         state_q;
	mcrp_pkg::cmd_t cmd_q;
	logic           rdy_q;
	state_t         state_nx;
	mcrp_pkg::cmd_t cmd_nx;
	logic           rdy_nx;

	always_comb begin
		state_nx = state_q;
		cmd_nx   = '0;
		rdy_nx   = rdy_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_DECODE;
					rdy_nx   = 1'b0;
				end
			end
			S_DECODE: begin
				state_nx         = S_DONE_CHK;
				cmd_nx.done_eval = 1'b1;
				unique case (stat.op)
					mcrp_pkg::OP_BEGIN: begin
						state_nx          = S_UPD_START;
						cmd_nx.done_eval  = 1'b0;
						cmd_nx.begin_init = 1'b1;
					end
					mcrp_pkg::OP_TICK: begin
						if (stat.tick_due) begin
							state_nx         = S_UPD_START;
							cmd_nx.done_eval = 1'b0;
						end
					end
					mcrp_pkg::OP_ADJ_DUR: begin
						if (stat.busy) begin
							state_nx         = S_ADJ_MUL;
							cmd_nx.done_eval = 1'b0;
							cmd_nx.adj_mul   = 1'b1;
						end
					end
					mcrp_pkg::OP_ADJ_SPEED: begin
						if (stat.busy && stat.spd_zero) begin
							state_nx         = S_UPD_START;
							cmd_nx.done_eval = 1'b0;
							cmd_nx.tgt_zero  = 1'b1;
						end else if (stat.busy && stat.spd_change) begin
							state_nx         = S_UPD_START;
							cmd_nx.done_eval = 1'b0;
							cmd_nx.tgt_load  = 1'b1;
						end
					end
					mcrp_pkg::OP_END: begin
						state_nx         = S_CLEAR;
						cmd_nx.done_eval = 1'b0;
						cmd_nx.end_clear = 1'b1;
					end
					default: ;
				endcase
			end
			S_CLEAR: begin
				state_nx         = S_DONE_CHK;
				cmd_nx.done_eval = 1'b1;
			end
			S_UPD_START: begin
				state_nx         = S_UPD_WAIT;
				cmd_nx.div_start = 1'b1;
			end
			S_UPD_WAIT: begin
				if (stat.div_done) begin
					state_nx          = S_UPD_MUL;
					cmd_nx.budget_mul = 1'b1;
				end
			end
			S_UPD_MUL: begin
				state_nx         = S_UPD_APPLY;
				cmd_nx.upd_apply = 1'b1;
			end
			S_UPD_APPLY: begin
				state_nx         = S_DONE_CHK;
				cmd_nx.done_eval = 1'b1;
			end
			S_ADJ_MUL: begin
				state_nx         = S_ADJ_APPLY;
				cmd_nx.adj_apply = 1'b1;
			end
			S_ADJ_APPLY: begin
				state_nx         = S_DONE_CHK;
				cmd_nx.done_eval = 1'b1;
			end
			S_DONE_CHK: begin
				state_nx    = S_EMIT;
				cmd_nx.emit = 1'b1;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					state_nx = S_IDLE;
					rdy_nx   = 1'b1;
				end else begin
					cmd_nx.emit = 1'b1;
				end
			end
			default: begin
				state_nx = S_IDLE;
				rdy_nx   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= state_nx;
			cmd_q   <= cmd_nx;
			rdy_q   <= rdy_nx;
		end
	end

	assign cmd      = cmd_q;
	assign in_ready = rdy_q;

endmodule

>>> sv/motor_channel_ramp_profiler_core.sv
`timescale 1ns / 1ps
// Top level of the motor channel ramp profiler: stream ports, configuration
// port and the controller/datapath pair. Depends on mcrp_pkg, mcrp_ctrl, mcrp_dp.
//
// Each input word carries one opcode (begin, tick, adjust duration, adjust
// speed, end) with the current millisecond time; each accepted word yields
// exactly one result word with the drive direction, magnitude, stop flag,
// command-done flag and busy flag.
// Configuration registers (speed step, update period, slide mode) are written
// through the cfg channel, which is always ready; index 0, 1 and 2 select them.
// Words are processed one at a time. Begin, a due tick and a speed
// adjustment that changes or zeroes the target run a profile update, which is
// bound by the one-bit-per-cycle 32-bit period divider. The result sits in an
// output register; s_tready rises again in the cycle the result is loaded
// there, so the next word can be taken even while the receiver stalls. A
// later result waits in the controller until the output register is free.
// Reset clears the channel state and loads the register defaults
// (step 10, period 100 ms, slide mode off); s_tready is high after reset.
module motor_channel_ramp_profiler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_ms[31:0], command_speed[39:32], duration_ms[71:40],
	// duration_adjust_s[79:72], speed_adjust[87:80], end_switch_count[95:88]
	input  logic [95:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// drive_forward[0], drive_magnitude[7:1], drive_stop[8], command_done[9],
	// channel_busy[10], zero fill [15:11]
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mcrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcrp_pkg::CFG_DATA_W-1:0] cfg_data
);

	mcrp_pkg::cmd_t              cmd_w;
	mcrp_pkg::stat_t             stat_w;
	logic                        accept;
	logic                        cfg_we;
	logic                        out_forward;
	logic [mcrp_pkg::MAG_W-1:0]  out_mag;
	logic                        out_stop;
	logic                        out_done;
	logic                        out_busy;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	mcrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.stat     (stat_w),
		.cmd      (cmd_w),
		.in_ready (s_tready)
	);

	mcrp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.op_in        (s_tuser),
		.now_in       (s_tdata[31:0]),
		.cmd_speed_in (s_tdata[39:32]),
		.dur_in       (s_tdata[71:40]),
		.adj_s_in     (s_tdata[79:72]),
		.adj_v_in     (s_tdata[87:80]),
		.count_in     (s_tdata[95:88]),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_index),
		.cfg_wdata    (cfg_data),
		.cmd          (cmd_w),
		.stat         (stat_w),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_forward  (out_forward),
		.out_mag      (out_mag),
		.out_stop     (out_stop),
		.out_done     (out_done),
		.out_busy     (out_busy)
	);

	assign m_tdata = {5'b0, out_busy, out_done, out_stop, out_mag, out_forward};

	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an earlier word was still in work");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd_w))
		else $error("controller issued more than one datapath command");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.emit && stat_w.out_free |=> m_tvalid)
		else $error("emitted result not presented on the output");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat_w.div_done |-> !s_tready)
		else $error("divider finished while the controller was idle");

endmodule
